// ===== hw/rtl/tedq_pkg.sv =====
// shared types and constants for the two-ended queue with key removal
// no dependencies
package tedq_pkg;

	localparam int KEY_W = 16;
	localparam int OCC_W = 7;

	typedef enum logic [1:0] {
		FN_PUSH_FRONT = 2'd0,
		FN_PUSH_BACK  = 2'd1,
		FN_SERVE      = 2'd2,
		FN_REMOVE     = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_ABSENT = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_INS,
		S_CMP,
		S_UNL
	} fsm_t;

	typedef struct packed {
		func_t             func;
		logic [KEY_W-1:0]  item_key;
	} cmd_t;

	typedef struct packed {
		status_t           status;
		logic [KEY_W-1:0]  removed_key;
		logic [OCC_W-1:0]  occupancy;
	} rsp_t;

endpackage

// ===== hw/rtl/two_ended_queue_with_key_removal.sv =====
// two-ended queue over linked slot memories, top level
// depends on tedq_pkg
// inserts pass S_INS; serve and remove walk S_CMP from the front to the match, then S_UNL
// failed inserts and empty-queue ops answer from S_IDLE; the list walk sets remove time
// one command at a time, taken while idle; results strobed on done for one cycle, no stall
// reset: asynchronous, empties the queue at once; the free list is tracked with a fill mark
module two_ended_queue_with_key_removal #(
	parameter int CAPACITY = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  tedq_pkg::cmd_t  cmd,
	output logic            done,
	output tedq_pkg::rsp_t  rsp
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int KW = tedq_pkg::KEY_W;

	logic [KW-1:0] key_mem [CAPACITY];
	logic [IW-1:0] fwd_mem [CAPACITY];
	logic [IW-1:0] bwd_mem [CAPACITY];

	tedq_pkg::fsm_t state_q, state_d;
	logic [IW-1:0] front_q, front_d, back_q, back_d, free_q, free_d, cur_q, cur_d;
	logic [CW-1:0] count_q, count_d, fresh_q, fresh_d, n_q, n_d;
	tedq_pkg::cmd_t op_q, op_d;
	logic [KW-1:0] rem_q, rem_d;
	logic done_q, done_d;
	tedq_pkg::rsp_t rsp_q, rsp_d;

	logic [IW-1:0] raddr, raddr_s1;
	logic [KW-1:0] key_rd;
	logic [IW-1:0] fwd_rd, bwd_rd, fwd_eff;
	logic key_we, fwd_we, bwd_we;
	logic [IW-1:0] key_wa, fwd_wa, fwd_wd, bwd_wa, bwd_wd;
	logic at_front, at_back, hit;

	always_ff @(posedge clk) begin
		if (key_we) key_mem[key_wa] <= op_q.item_key;
		if (fwd_we) fwd_mem[fwd_wa] <= fwd_wd;
		if (bwd_we) bwd_mem[bwd_wa] <= bwd_wd;
		key_rd   <= key_mem[raddr];
		fwd_rd   <= fwd_mem[raddr];
		bwd_rd   <= bwd_mem[raddr];
		raddr_s1 <= raddr;
	end

	// slots at or past the fill mark were never written; their link is taken as the next slot index
	always_comb begin
		if ({{(CW-IW){1'b0}}, raddr_s1} >= fresh_q)
			fwd_eff = (raddr_s1 == IW'(CAPACITY - 1)) ? '0 : raddr_s1 + 1'b1;
		else
			fwd_eff = fwd_rd;
	end

	assign at_front = (count_q == CW'(1)) || (cur_q == front_q);
	assign at_back  = (count_q == CW'(1)) || (cur_q == back_q);
	assign hit      = (op_q.func == tedq_pkg::FN_SERVE) || (key_rd == op_q.item_key);

	always_comb begin
		state_d = state_q;
		front_d = front_q;
		back_d  = back_q;
		free_d  = free_q;
		cur_d   = cur_q;
		count_d = count_q;
		fresh_d = fresh_q;
		n_d     = n_q;
		op_d    = op_q;
		rem_d   = rem_q;
		done_d  = 1'b0;
		rsp_d   = rsp_q;
		raddr   = front_q;
		key_we  = 1'b0;
		key_wa  = free_q;
		fwd_we  = 1'b0;
		fwd_wa  = '0;
		fwd_wd  = '0;
		bwd_we  = 1'b0;
		bwd_wa  = '0;
		bwd_wd  = '0;
		case (state_q)
			tedq_pkg::S_IDLE: begin
				if (cmd.func == tedq_pkg::FN_PUSH_FRONT || cmd.func == tedq_pkg::FN_PUSH_BACK)
					raddr = free_q;
				if (start) begin
					op_d  = cmd;
					cur_d = front_q;
					n_d   = '0;
					if (cmd.func == tedq_pkg::FN_PUSH_FRONT
							|| cmd.func == tedq_pkg::FN_PUSH_BACK) begin
						if (count_q >= CW'(CAPACITY)) begin
							done_d = 1'b1;
							rsp_d  = '{tedq_pkg::ST_FULL, '0, tedq_pkg::OCC_W'(count_q)};
						end else begin
							state_d = tedq_pkg::S_INS;
						end
					end else if (count_q == '0) begin
						done_d = 1'b1;
						rsp_d  = '{tedq_pkg::ST_EMPTY, '0, tedq_pkg::OCC_W'(count_q)};
					end else begin
						state_d = tedq_pkg::S_CMP;
					end
				end
			end
			tedq_pkg::S_INS: begin
				key_we = 1'b1;
				if (count_q == '0) begin
					front_d = free_q;
					back_d  = free_q;
				end else if (op_q.func == tedq_pkg::FN_PUSH_FRONT) begin
					fwd_we  = 1'b1;
					fwd_wa  = free_q;
					fwd_wd  = front_q;
					bwd_we  = 1'b1;
					bwd_wa  = front_q;
					bwd_wd  = free_q;
					front_d = free_q;
				end else begin
					bwd_we = 1'b1;
					bwd_wa = free_q;
					bwd_wd = back_q;
					fwd_we = 1'b1;
					fwd_wa = back_q;
					fwd_wd = free_q;
					back_d = free_q;
				end
				free_d = fwd_eff;
				if ({{(CW-IW){1'b0}}, free_q} == fresh_q) fresh_d = fresh_q + 1'b1;
				count_d = count_q + 1'b1;
				done_d  = 1'b1;
				rsp_d   = '{tedq_pkg::ST_DONE, '0, tedq_pkg::OCC_W'(count_q + 1'b1)};
				state_d = tedq_pkg::S_IDLE;
			end
			tedq_pkg::S_CMP: begin
				raddr = fwd_rd;
				if (hit) begin
					rem_d = key_rd;
					if (!at_front) begin
						fwd_we = 1'b1;
						fwd_wa = bwd_rd;
						fwd_wd = fwd_rd;
					end
					if (!at_back) begin
						bwd_we = 1'b1;
						bwd_wa = fwd_rd;
						bwd_wd = bwd_rd;
					end
					if (at_front) front_d = fwd_rd;
					if (at_back) back_d = bwd_rd;
					state_d = tedq_pkg::S_UNL;
				end else if (n_q + 1'b1 == count_q) begin
					done_d  = 1'b1;
					rsp_d   = '{tedq_pkg::ST_ABSENT, '0, tedq_pkg::OCC_W'(count_q)};
					state_d = tedq_pkg::S_IDLE;
				end else begin
					cur_d = fwd_rd;
					n_d   = n_q + 1'b1;
				end
			end
			tedq_pkg::S_UNL: begin
				fwd_we  = 1'b1;
				fwd_wa  = cur_q;
				fwd_wd  = free_q;
				free_d  = cur_q;
				count_d = count_q - 1'b1;
				done_d  = 1'b1;
				rsp_d   = '{tedq_pkg::ST_DONE, rem_q, tedq_pkg::OCC_W'(count_q - 1'b1)};
				state_d = tedq_pkg::S_IDLE;
			end
			default: state_d = tedq_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tedq_pkg::S_IDLE;
			front_q <= '0;
			back_q  <= '0;
			free_q  <= '0;
			count_q <= '0;
			fresh_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			back_q  <= back_d;
			free_q  <= free_d;
			count_q <= count_d;
			fresh_q <= fresh_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		n_q   <= n_d;
		op_q  <= op_d;
		rem_q <= rem_d;
		rsp_q <= rsp_d;
	end

	assign busy = (state_q != tedq_pkg::S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("item count above capacity");

	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= fresh_q)
		else $error("more items than slots ever used");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tedq_pkg::S_CMP |-> n_q < count_q)
		else $error("list walk ran past item count");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy) || $past(start))
		else $error("result without transaction");

endmodule

// ===== tb/sv/two_ended_queue_with_key_removal_chk.sv =====
// checker for the two-ended queue: watches accepted commands and strobed responses
// keeps its own deque of identifiers and compares each response field by field
// depends on tedq_pkg
module two_ended_queue_with_key_removal_chk #(
	parameter int CAPACITY = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  tedq_pkg::cmd_t  cmd,
	input  logic            done,
	input  tedq_pkg::rsp_t  rsp,
	output int              fail_count,
	output int              pending,
	output int              rsp_count
);

	logic [tedq_pkg::KEY_W-1:0] deque_keys[$];
	tedq_pkg::rsp_t expected_rsps[$];

	function automatic tedq_pkg::rsp_t apply_cmd(tedq_pkg::cmd_t c);
		tedq_pkg::rsp_t r;
		int idx;
		r.status = tedq_pkg::ST_DONE;
		r.removed_key = '0;
		idx = -1;
		case (c.func)
			tedq_pkg::FN_PUSH_FRONT, tedq_pkg::FN_PUSH_BACK: begin
				if (deque_keys.size() >= CAPACITY)
					r.status = tedq_pkg::ST_FULL;
				else if (c.func == tedq_pkg::FN_PUSH_FRONT)
					deque_keys.push_front(c.item_key);
				else
					deque_keys.push_back(c.item_key);
			end
			tedq_pkg::FN_SERVE: begin
				if (deque_keys.size() == 0)
					r.status = tedq_pkg::ST_EMPTY;
				else
					r.removed_key = deque_keys.pop_front();
			end
			default: begin
				if (deque_keys.size() == 0) begin
					r.status = tedq_pkg::ST_EMPTY;
				end else begin
					for (int i = 0; i < deque_keys.size(); i++)
						if (idx < 0 && deque_keys[i] == c.item_key)
							idx = i;
					if (idx < 0) begin
						r.status = tedq_pkg::ST_ABSENT;
					end else begin
						r.removed_key = deque_keys[idx];
						deque_keys.delete(idx);
					end
				end
			end
		endcase
		r.occupancy = tedq_pkg::OCC_W'(deque_keys.size());
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $time, what);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		rsp_count = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		tedq_pkg::rsp_t e;
		if (arst_n) begin
			if (done) begin
				rsp_count++;
				if (expected_rsps.size() == 0) begin
					report_mismatch("response with no transaction outstanding");
				end else begin
					e = expected_rsps.pop_front();
					if (rsp.status !== e.status)
						report_mismatch($sformatf("status %0d, want %0d", rsp.status, e.status));
					if (rsp.removed_key !== e.removed_key)
						report_mismatch($sformatf("removed_key %h, want %h",
							rsp.removed_key, e.removed_key));
					if (rsp.occupancy !== e.occupancy)
						report_mismatch($sformatf("occupancy %0d, want %0d",
							rsp.occupancy, e.occupancy));
				end
			end
			if (start && !busy)
				expected_rsps.push_back(apply_cmd(cmd));
			pending = expected_rsps.size();
		end
	end

endmodule

// ===== tb/sv/two_ended_queue_with_key_removal_tb.sv =====
// testbench top for the two-ended queue: directed and random command stimulus
// depends on tedq_pkg, the block and two_ended_queue_with_key_removal_chk
module two_ended_queue_with_key_removal_tb;

	localparam int CAP = 64;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	tedq_pkg::cmd_t cmd;
	logic done;
	tedq_pkg::rsp_t rsp;
	int fail_count;
	int pending;
	int rsp_count;
	int cycles;
	int sent;
	logic [tedq_pkg::KEY_W-1:0] used_keys[$];

	two_ended_queue_with_key_removal #(.CAPACITY(CAP)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .rsp(rsp)
	);

	two_ended_queue_with_key_removal_chk #(.CAPACITY(CAP)) i_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .rsp(rsp), .fail_count(fail_count), .pending(pending),
		.rsp_count(rsp_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// one command transaction, then an optional random gap
	task automatic issue(tedq_pkg::func_t f, logic [tedq_pkg::KEY_W-1:0] k, bit allow_gap);
		int gap;
		start <= 1'b1;
		cmd <= '{func: f, item_key: k};
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent++;
		if (f == tedq_pkg::FN_PUSH_FRONT || f == tedq_pkg::FN_PUSH_BACK) begin
			used_keys.push_back(k);
			if (used_keys.size() > 40)
				void'(used_keys.pop_front());
		end
		gap = 0;
		if (allow_gap)
			case ($urandom_range(0, 9))
				0, 1, 2: gap = $urandom_range(1, 3);
				3: gap = $urandom_range(10, 80);
				default: gap = 0;
			endcase
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap)
				@(posedge clk);
		end
	endtask

	function automatic logic [tedq_pkg::KEY_W-1:0] pick_key();
		if (used_keys.size() > 0 && $urandom_range(0, 3) != 0)
			return used_keys[$urandom_range(0, used_keys.size() - 1)];
		return tedq_pkg::KEY_W'($urandom_range(0, 15));
	endfunction

	initial begin
		int burst;
		logic [tedq_pkg::KEY_W-1:0] k;
		cycles = 0;
		sent = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '{func: tedq_pkg::FN_PUSH_FRONT, item_key: '0};
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty cases, extremes of the key, duplicates, full store
		issue(tedq_pkg::FN_SERVE, 16'h0000, 1'b0);
		issue(tedq_pkg::FN_REMOVE, 16'hffff, 1'b0);
		issue(tedq_pkg::FN_PUSH_BACK, 16'hffff, 1'b0);
		issue(tedq_pkg::FN_PUSH_FRONT, 16'h0000, 1'b0);
		issue(tedq_pkg::FN_PUSH_BACK, 16'h5a5a, 1'b0);
		issue(tedq_pkg::FN_PUSH_BACK, 16'h5a5a, 1'b0);
		issue(tedq_pkg::FN_REMOVE, 16'h1234, 1'b0);
		issue(tedq_pkg::FN_REMOVE, 16'h5a5a, 1'b0);
		issue(tedq_pkg::FN_REMOVE, 16'hffff, 1'b0);
		issue(tedq_pkg::FN_SERVE, 16'h0000, 1'b0);
		issue(tedq_pkg::FN_REMOVE, 16'h5a5a, 1'b0);
		issue(tedq_pkg::FN_SERVE, 16'h0000, 1'b0);
		for (int i = 0; i < CAP; i++)
			issue(i[0] ? tedq_pkg::FN_PUSH_FRONT : tedq_pkg::FN_PUSH_BACK,
				tedq_pkg::KEY_W'(i * 1031), 1'b0);
		issue(tedq_pkg::FN_PUSH_FRONT, 16'ha5a5, 1'b0);
		issue(tedq_pkg::FN_PUSH_BACK, 16'ha5a5, 1'b0);
		issue(tedq_pkg::FN_REMOVE, tedq_pkg::KEY_W'(62 * 1031), 1'b0);

		// random phases biased toward filling, draining or mixing
		while (sent < 1800) begin
			burst = $urandom_range(20, 120);
			case ($urandom_range(0, 2))
				0: for (int i = 0; i < burst; i++) begin
					k = $urandom_range(0, 3) == 0 ? tedq_pkg::KEY_W'($urandom) : pick_key();
					issue($urandom_range(0, 5) < 5 ? tedq_pkg::func_t'($urandom_range(0, 1))
						: tedq_pkg::func_t'($urandom_range(2, 3)), k, 1'b1);
				end
				1: for (int i = 0; i < burst; i++)
					issue($urandom_range(0, 5) < 5 ? tedq_pkg::func_t'($urandom_range(2, 3))
						: tedq_pkg::func_t'($urandom_range(0, 1)), pick_key(), 1'b1);
				default: for (int i = 0; i < burst; i++)
					issue(tedq_pkg::func_t'($urandom_range(0, 3)), pick_key(), 1'b1);
			endcase
		end
		start <= 1'b0;

		while (pending > 0)
			@(posedge clk);
		repeat (CAP + 10)
			@(posedge clk);
		$display("sent %0d commands, checked %0d responses", sent, rsp_count);
		if (fail_count == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
